// ===== rtl/alr_pkg.sv =====
// Shared constants, types and helpers for the area-average line resampler.
`default_nettype none

package alr_pkg;

  localparam int MAX_LEN    = 4096;
  localparam int CFG_W      = 13;
  localparam int IDX_W_CFG  = 2;
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int CH_W       = 8;
  localparam int SUM_W      = CH_W + $clog2(MAX_LEN);
  localparam int PROD_W     = CH_W + LEN_W;
  localparam int RESULT_CAP = 64;
  localparam int BUF_IDX_W  = $clog2(RESULT_CAP);
  localparam int BUF_CNT_W  = $clog2(RESULT_CAP + 1);
  localparam int PIX_W      = 4 * CH_W;

  localparam logic [IDX_W_CFG-1:0] REG_IN_LEN  = IDX_W_CFG'(0);
  localparam logic [IDX_W_CFG-1:0] REG_OUT_LEN = IDX_W_CFG'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_CHECK,
    S_DSTART,
    S_DWAIT,
    S_WRITE,
    S_NEXT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  typedef struct packed {
    logic            done;
    logic [CH_W-1:0] quot;
  } div_stat_t;

  // Map a raw length register to its working range 1..MAX_LEN.
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > 32'(MAX_LEN)) begin
      r = LEN_W'(MAX_LEN);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/alr_div.sv =====
// Restoring divider: one quotient bit per cycle, 8-bit quotient.
`default_nettype none

module alr_div
  import alr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [LEN_W-1:0] divisor,
  output div_stat_t             stat
);

  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [CH_W-1:0]  low_r, low_nxt;
  logic [CH_W-1:0]  q_r, q_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [LEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial    = {rem_r, low_r[CH_W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = LEN_W'(dividend >> CH_W);
      low_nxt  = dividend[CH_W-1:0];
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? LEN_W'(trial - {1'b0, divisor}) : LEN_W'(trial);
      low_nxt = {low_r[CH_W-2:0], 1'b0};
      q_nxt   = {q_r[CH_W-2:0], ge};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
    stat.done = busy_r && (cnt_r == 3'd7);
    stat.quot = {q_r[CH_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/area_average_line_resampler.sv =====
// Top level of the area-average line resampler: sequencer, sums, result buffer.
//
//  channel | ports                                             | transaction
//  --------+---------------------------------------------------+------------------------
//  in      | in_valid, in_ready, in_src_pixel                  | one source pixel
//  out     | out_valid, out_ready, out_pixel, out_run_last,    | one averaged pixel
//          | out_line_done, out_overflow                       |
//  cfg     | cfg_we, cfg_index, cfg_data                       | one register write
//
// One source pixel walks its overlaps in steps: one multiply-accumulate per channel
// on the shared 8x13 multiplier, a check and a next-step decision. Each result kept
// adds four passes through the bit-serial divider, one per channel, and a buffer
// write. Results then leave one at a time through the output register, held back
// while out_ready is low.
// in_ready is high only between pixels and drops during a register write; the last
// result may still wait in the output register while the next pixel is taken.
// Reset is synchronous and needs no sweep.
`default_nettype none

module area_average_line_resampler
  import alr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     in_src_pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_pixel,
  output logic                      out_run_last,
  output logic                      out_line_done,
  output logic                      out_overflow,
  input  wire logic                 cfg_we,
  input  wire logic [IDX_W_CFG-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  state_t state_r, state_nxt;

  // Configuration and line state.
  logic [CFG_W-1:0] in_len_r, in_len_nxt;
  logic [CFG_W-1:0] out_len_r, out_len_nxt;
  logic [LEN_W-1:0] src_r, src_nxt;
  logic [LEN_W-1:0] dst_r, dst_nxt;
  logic [LEN_W-1:0] oidx_r, oidx_nxt;
  logic [SUM_W-1:0] sums_r [4];
  logic [SUM_W-1:0] sums_nxt [4];

  // Per-pixel working state.
  logic [PIX_W-1:0]     px_r, px_nxt;
  logic [1:0]           ch_r, ch_nxt;
  logic [PIX_W-1:0]     pix_r, pix_nxt;
  logic [BUF_CNT_W-1:0] n_r, n_nxt;
  logic [BUF_CNT_W-1:0] k_r, k_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 done_r, done_nxt;

  // Output register.
  logic             ov_r, ov_nxt;
  logic [PIX_W-1:0] opix_r, opix_nxt;
  logic             olast_r, olast_nxt;
  logic             odone_r, odone_nxt;
  logic             oovf_r, oovf_nxt;

  // Result buffer.
  logic [PIX_W-1:0] buf_mem [RESULT_CAP];
  logic [PIX_W-1:0] rd_data_r;
  logic             buf_we;

  logic [LEN_W-1:0]  il, ol, fv;
  logic [CH_W-1:0]   chan;
  logic [PROD_W-1:0] prod;
  logic [LEN_W:0]    oidx_inc;
  logic              div_start;
  div_stat_t         div_stat;
  logic              emit_last;

  assign il   = eff_len(in_len_r);
  assign ol   = eff_len(out_len_r);
  assign fv   = (src_r < dst_r) ? src_r : dst_r;
  assign chan = px_r[ch_r*CH_W +: CH_W];
  assign prod = PROD_W'(chan) * PROD_W'(fv);

  assign oidx_inc  = {1'b0, oidx_r} + (LEN_W+1)'(1);
  assign emit_last = (k_r + BUF_CNT_W'(1)) == n_r;

  alr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sums_r[ch_r]),
    .divisor  (il),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt   = state_r;
    in_len_nxt  = in_len_r;
    out_len_nxt = out_len_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    oidx_nxt    = oidx_r;
    sums_nxt    = sums_r;
    px_nxt      = px_r;
    ch_nxt      = ch_r;
    pix_nxt     = pix_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    ovf_nxt     = ovf_r;
    done_nxt    = done_r;
    ov_nxt      = ov_r;
    opix_nxt    = opix_r;
    olast_nxt   = olast_r;
    odone_nxt   = odone_r;
    oovf_nxt    = oovf_r;
    div_start   = 1'b0;
    buf_we      = 1'b0;
    in_ready    = (state_r == S_IDLE) && !cfg_we;

    // Drop the output transaction once taken.
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we && (cfg_index == REG_IN_LEN || cfg_index == REG_OUT_LEN)) begin
          // A listed write restarts the line with the new lengths.
          if (cfg_index == REG_IN_LEN) begin
            in_len_nxt = cfg_data;
          end else begin
            out_len_nxt = cfg_data;
          end
          src_nxt  = eff_len(out_len_nxt);
          dst_nxt  = eff_len(in_len_nxt);
          oidx_nxt = '0;
          for (int p = 0; p < 4; p++) begin
            sums_nxt[p] = '0;
          end
        end else if (in_valid && !cfg_we) begin
          px_nxt   = in_src_pixel;
          ch_nxt   = '0;
          n_nxt    = '0;
          k_nxt    = '0;
          ovf_nxt  = 1'b0;
          done_nxt = 1'b0;
          // Hold counters inside their legal ranges.
          if (src_r == '0 || src_r > ol) begin
            src_nxt = ol;
          end
          if (dst_r == '0 || dst_r > il) begin
            dst_nxt = il;
          end
          state_nxt = S_ACC;
        end
      end

      S_ACC: begin
        // Accumulate one channel per cycle through the shared multiplier.
        sums_nxt[ch_r] = sums_r[ch_r] + SUM_W'(prod);
        ch_nxt         = ch_r + 2'd1;
        if (ch_r == 2'd3) begin
          src_nxt   = src_r - fv;
          dst_nxt   = dst_r - fv;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (dst_r == '0) begin
          // Result pixel complete: advance the line position.
          dst_nxt = il;
          if (oidx_inc >= {1'b0, ol}) begin
            oidx_nxt = '0;
            done_nxt = 1'b1;
          end else begin
            oidx_nxt = LEN_W'(oidx_inc);
          end
          if (n_r < BUF_CNT_W'(RESULT_CAP)) begin
            ch_nxt    = '0;
            state_nxt = S_DSTART;
          end else begin
            // Buffer full: drop this result but keep the state moving.
            ovf_nxt = 1'b1;
            for (int p = 0; p < 4; p++) begin
              sums_nxt[p] = '0;
            end
            state_nxt = S_NEXT;
          end
        end else begin
          state_nxt = S_NEXT;
        end
      end

      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end

      S_DWAIT: begin
        if (div_stat.done) begin
          pix_nxt = {div_stat.quot, pix_r[PIX_W-1:CH_W]};
          ch_nxt  = ch_r + 2'd1;
          if (ch_r == 2'd3) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_DSTART;
          end
        end
      end

      S_WRITE: begin
        buf_we = 1'b1;
        n_nxt  = n_r + BUF_CNT_W'(1);
        for (int p = 0; p < 4; p++) begin
          sums_nxt[p] = '0;
        end
        state_nxt = S_NEXT;
      end

      S_NEXT: begin
        ch_nxt = '0;
        if (src_r == '0) begin
          src_nxt = ol;
          if (n_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end else begin
          state_nxt = S_ACC;
        end
      end

      S_EMIT_RD: begin
        // Wait for a free output register; the buffer read runs meanwhile.
        if (!ov_r) begin
          state_nxt = S_EMIT_LD;
        end
      end

      S_EMIT_LD: begin
        ov_nxt    = 1'b1;
        opix_nxt  = rd_data_r;
        olast_nxt = emit_last;
        odone_nxt = emit_last && done_r;
        oovf_nxt  = ovf_r;
        k_nxt     = k_r + BUF_CNT_W'(1);
        if (emit_last) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_len_r  <= CFG_W'(1);
      out_len_r <= CFG_W'(2048);
      src_r     <= eff_len(CFG_W'(2048));
      dst_r     <= eff_len(CFG_W'(1));
      oidx_r    <= '0;
      for (int p = 0; p < 4; p++) begin
        sums_r[p] <= '0;
      end
      ov_r      <= 1'b0;
      ch_r      <= '0;
      n_r       <= '0;
      k_r       <= '0;
      ovf_r     <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_len_r  <= in_len_nxt;
      out_len_r <= out_len_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      oidx_r    <= oidx_nxt;
      sums_r    <= sums_nxt;
      ov_r      <= ov_nxt;
      ch_r      <= ch_nxt;
      n_r       <= n_nxt;
      k_r       <= k_nxt;
      ovf_r     <= ovf_nxt;
      done_r    <= done_nxt;
    end
    px_r    <= px_nxt;
    pix_r   <= pix_nxt;
    opix_r  <= opix_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
    oovf_r  <= oovf_nxt;
  end

  // Result buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[n_r[BUF_IDX_W-1:0]] <= pix_r;
    end
    rd_data_r <= buf_mem[k_r[BUF_IDX_W-1:0]];
  end

  assign out_valid     = ov_r;
  assign out_pixel     = opix_r;
  assign out_run_last  = olast_r;
  assign out_line_done = odone_r;
  assign out_overflow  = oovf_r;

endmodule

`default_nettype wire
